>>> rtl/circular_deque_engine_assert.svh
// Assertion macros shared by the deque RTL
`ifndef CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold
`define CDQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdq assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle
`define CDQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdq assertion failed");
`else
`define CDQ_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CDQ_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/cdq_pkg.sv
// Shared types and constants of the circular deque engine
`default_nettype none
package cdq_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int CAP_W          = 5;
   localparam int CNT_W          = 5;
   localparam int MODE_W         = 2;
   localparam int STATUS_W       = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_REAR  = 2'd1,
      MODE_REM_FRONT = 2'd2,
      MODE_REM_REAR  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage
`default_nettype wire

>>> rtl/cdq_chan_if.sv
// Request and response channel interfaces of the circular deque engine
`default_nettype none
interface cdq_req_if import cdq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] item_value;

   modport source (output valid, output mode, output item_value, input ready);
   modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] removed_value;
   logic [STATUS_W-1:0]      status;
   logic [CNT_W-1:0]         occupancy;
   logic                     is_empty;
   logic                     is_full;
   logic signed [DATA_W-1:0] head_value;
   logic signed [DATA_W-1:0] tail_value;

   modport source (output valid, output removed_value, output status, output occupancy,
                   output is_empty, output is_full, output head_value, output tail_value,
                   input ready);
   modport sink   (input valid, input removed_value, input status, input occupancy,
                   input is_empty, input is_full, input head_value, input tail_value,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/circular_deque_engine.sv
// Top level of the circular deque engine: ring pointers, word cache and result register
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------------------
//   req_bus  | in  | valid / ready    | mode, item_value
//   rsp_bus  | out | valid / ready    | removed_value, status, occupancy, is_empty,
//            |     |                  | is_full, head_value, tail_value
//   csr_*    | in  | csr_wr_en        | csr_wr_data (capacity in use)
//
// Inserts and rejected operations load the result register at the request beat. A
// removal that leaves words behind passes through the fetch state first, where the
// registered read data of the ring RAM gives the new front or rear word.
// A new request beat is taken in the idle state while the previous result waits, as
// long as the result register is free or drains in that same cycle.
// Reset is synchronous and active high; it empties the deque and sets the capacity to
// 16. The RAM is not cleared; only a capacity change lets unwritten entries be read.
`default_nettype none
`include "circular_deque_engine_assert.svh"
module circular_deque_engine import cdq_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   cdq_req_if.sink               req_bus,
   cdq_rsp_if.source             rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   // Width wide enough for both the capacity register and a pointer plus one
   localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

   typedef enum logic [0:0] {
      S_IDLE,
      S_FETCH
   } state_type;

   // Step a pointer forward, wrapping at the capacity in use
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CMP_W-1:0] cap);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(idx) + CMP_W'(1);
      return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
   endfunction

   // Step a pointer back, wrapping from entry zero to the last entry in use
   function automatic logic [IDX_W-1:0] retreat(input logic [IDX_W-1:0] idx,
                                                input logic [CMP_W-1:0] cap);
      logic [CMP_W-1:0] last;
      last = cap - CMP_W'(1);
      return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
   endfunction

   // Architectural state
   state_type                state_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [IDX_W-1:0]         tail_ff;
   logic [CNT_W-1:0]         count_ff;
   // Cached copies of the words at both ends, so peeks need no RAM read
   logic signed [DATA_W-1:0] head_val_ff;
   logic signed [DATA_W-1:0] tail_val_ff;
   logic                     fetch_front_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff;
   status_type               rsp_status_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_empty_ff;
   logic                     rsp_full_ff;
   logic signed [DATA_W-1:0] rsp_head_ff;
   logic signed [DATA_W-1:0] rsp_tail_ff;

   // Next-state values for an accepted request
   logic [IDX_W-1:0]         head_in;
   logic [IDX_W-1:0]         tail_in;
   logic [CNT_W-1:0]         count_in;
   logic signed [DATA_W-1:0] head_val_in;
   logic signed [DATA_W-1:0] tail_val_in;
   logic signed [DATA_W-1:0] removed_in;
   status_type               status_in;
   logic                     go_fetch;
   logic                     out_empty;
   logic                     out_full;

   logic [CMP_W-1:0]         eff_cap;
   mode_type                 req_mode;
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     is_empty;
   logic                     is_full;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic                     ram_re;
   logic [IDX_W-1:0]         ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;

   // Clamp the capacity register into one to RING_DEPTH
   always_comb begin
      eff_cap = CMP_W'(cap_ff);
      if (eff_cap == '0) begin
         eff_cap = CMP_W'(1);
      end else if (eff_cap > CMP_W'(RING_DEPTH)) begin
         eff_cap = CMP_W'(RING_DEPTH);
      end
   end

   assign req_mode = mode_type'(req_bus.mode);
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;
   // Take a beat only when idle and the result slot is free or drains now
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire = req_bus.valid && req_bus.ready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (CMP_W'(count_ff) >= eff_cap);

   // Decode the operation and work out the pointers, count and end words
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      head_val_in = head_val_ff;
      tail_val_in = tail_val_ff;
      removed_in  = '0;
      status_in   = ST_DONE;
      go_fetch    = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = head_ff;
      ram_re      = 1'b0;
      ram_raddr   = head_ff;
      unique case (req_mode) inside
         MODE_INS_FRONT, MODE_INS_REAR: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               ram_we   = req_fire;
               if (is_empty) begin
                  // First word: both ends land on entry zero
                  head_in     = '0;
                  tail_in     = '0;
                  ram_waddr   = '0;
                  head_val_in = req_bus.item_value;
                  tail_val_in = req_bus.item_value;
               end else if (req_mode == MODE_INS_FRONT) begin
                  head_in     = retreat(head_ff, eff_cap);
                  ram_waddr   = head_in;
                  head_val_in = req_bus.item_value;
                  // After a capacity shrink the new front can share the rear entry
                  if (head_in == tail_ff) begin
                     tail_val_in = req_bus.item_value;
                  end
               end else begin
                  tail_in     = advance(tail_ff, eff_cap);
                  ram_waddr   = tail_in;
                  tail_val_in = req_bus.item_value;
                  // After a capacity shrink the new rear can share the front entry
                  if (tail_in == head_ff) begin
                     head_val_in = req_bus.item_value;
                  end
               end
            end
         end
         MODE_REM_FRONT, MODE_REM_REAR: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (req_mode == MODE_REM_FRONT) begin
                  removed_in = head_val_ff;
                  head_in    = advance(head_ff, eff_cap);
                  ram_raddr  = head_in;
               end else begin
                  removed_in = tail_val_ff;
                  tail_in    = retreat(tail_ff, eff_cap);
                  ram_raddr  = tail_in;
               end
               if (count_ff == CNT_W'(1)) begin
                  // Last word gone: park both pointers at entry zero
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  // Fetch the word that becomes the new end
                  go_fetch = 1'b1;
                  ram_re   = req_fire;
               end
            end
         end
      endcase
   end

   assign out_empty = (count_in == '0);
   assign out_full  = (CMP_W'(count_in) >= eff_cap);

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (DATA_W'(unsigned'(req_bus.item_value))),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // State machine, pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         // Drop the result once the beat goes out, unless a new one loads now
         if (rsp_fire && !(req_fire && !go_fetch)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  head_ff        <= head_in;
                  tail_ff        <= tail_in;
                  count_ff       <= count_in;
                  head_val_ff    <= head_val_in;
                  tail_val_ff    <= tail_val_in;
                  fetch_front_ff <= (req_mode == MODE_REM_FRONT);
                  rsp_removed_ff <= removed_in;
                  rsp_status_ff  <= status_in;
                  rsp_count_ff   <= count_in;
                  rsp_empty_ff   <= out_empty;
                  rsp_full_ff    <= out_full;
                  rsp_head_ff    <= out_empty ? '0 : head_val_in;
                  rsp_tail_ff    <= out_empty ? '0 : tail_val_in;
                  if (go_fetch) begin
                     state_ff <= S_FETCH;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_FETCH: begin
               // RAM data is the new end word; finish the result
               if (fetch_front_ff) begin
                  head_val_ff <= $signed(ram_rdata);
                  rsp_head_ff <= $signed(ram_rdata);
               end else begin
                  tail_val_ff <= $signed(ram_rdata);
                  rsp_tail_ff <= $signed(ram_rdata);
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.removed_value = rsp_removed_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.occupancy     = rsp_count_ff;
   assign rsp_bus.is_empty      = rsp_empty_ff;
   assign rsp_bus.is_full       = rsp_full_ff;
   assign rsp_bus.head_value    = rsp_head_ff;
   assign rsp_bus.tail_value    = rsp_tail_ff;

   // The fetch cycle may only run with the result slot empty
   `CDQ_ASSERT_IMPL(a_fetch_slot_free, clock, reset, state_ff == S_FETCH, !rsp_valid_ff)
   // A fetch always returns to idle and presents the result in the next cycle
   `CDQ_ASSERT_NEXT(a_fetch_done, clock, reset, state_ff == S_FETCH, state_ff == S_IDLE && rsp_valid_ff)
   // An empty deque keeps both pointers parked at entry zero
   `CDQ_ASSERT_IMPL(a_empty_parked, clock, reset, count_ff == '0, head_ff == '0 && tail_ff == '0)
   // Peek values read zero on an empty result
   `CDQ_ASSERT_IMPL(a_empty_peek, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_head_ff == '0 && rsp_tail_ff == '0)
   // The word count never exceeds the ring size
   `CDQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, CMP_W'(count_ff) <= CMP_W'(RING_DEPTH))

endmodule
`default_nettype wire

>>> tb/sv/circular_deque_engine_tb.sv
// Self-checking testbench of the circular deque engine with its own deque predictor
`default_nettype none
module circular_deque_engine_tb;
   import cdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Snapshot of one response beat: the operation outcome plus the deque after it
   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      status_type               status;
      logic [CNT_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
      logic signed [DATA_W-1:0] head_value;
      logic signed [DATA_W-1:0] tail_value;
   } deque_view_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow deque: ring contents, pointers, fill level and capacity setting.
   // ring_written tracks which entries hold a word since reset; a capacity
   // change with words stored is only made once every entry has been written,
   // so no step ever looks at an entry the engine never stored.
   logic [DATA_W-1:0]       ring_words [RING_DEPTH_DEF];
   bit [RING_DEPTH_DEF-1:0] ring_written;
   int unsigned             head_ptr;
   int unsigned             tail_ptr;
   int unsigned             word_count;
   logic [CAP_W-1:0]        cap_setting;

   deque_view_type expected_views [$];
   int             mismatches;
   bit             steady;   // when set, neither side idles

   // Clock: 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the engine hangs a handshake
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Zero acts as one, anything past the ring depth acts as the ring depth
   function automatic int unsigned eff_capacity();
      if (cap_setting == '0) return 1;
      if (cap_setting > RING_DEPTH_DEF) return RING_DEPTH_DEF;
      return 32'(cap_setting);
   endfunction

   function automatic void store_word(input int unsigned idx, input logic [DATA_W-1:0] word);
      ring_words[idx]   = word;
      ring_written[idx] = 1'b1;
   endfunction

   // Apply one operation to the shadow deque and return the beat it must produce
   function automatic deque_view_type deque_step(input mode_type op,
                                                 input logic [DATA_W-1:0] word);
      int unsigned lim;
      deque_view_type v;
      lim = eff_capacity();
      v = '0;
      v.status = ST_DONE;
      if (op == MODE_INS_FRONT || op == MODE_INS_REAR) begin
         if (word_count >= lim) begin
            v.status = ST_FULL;
         end else begin
            if (word_count == 0) begin
               // first word always lands in entry 0
               head_ptr = 0;
               tail_ptr = 0;
               store_word(0, word);
            end else if (op == MODE_INS_FRONT) begin
               head_ptr = (head_ptr == 0) ? lim - 1 : head_ptr - 1;
               store_word(head_ptr, word);
            end else begin
               tail_ptr = (tail_ptr + 1 >= lim) ? 0 : tail_ptr + 1;
               store_word(tail_ptr, word);
            end
            word_count++;
         end
      end else begin
         if (word_count == 0) begin
            v.status = ST_EMPTY;
         end else begin
            if (op == MODE_REM_FRONT) begin
               v.removed_value = ring_words[head_ptr];
               head_ptr = (head_ptr + 1 >= lim) ? 0 : head_ptr + 1;
            end else begin
               v.removed_value = ring_words[tail_ptr];
               tail_ptr = (tail_ptr == 0) ? lim - 1 : tail_ptr - 1;
            end
            word_count--;
            // last word out: both pointers go home
            if (word_count == 0) begin
               head_ptr = 0;
               tail_ptr = 0;
            end
         end
      end
      v.occupancy = word_count[CNT_W-1:0];
      v.is_empty  = (word_count == 0);
      v.is_full   = (word_count >= lim);
      v.head_value = v.is_empty ? '0 : ring_words[head_ptr];
      v.tail_value = v.is_empty ? '0 : ring_words[tail_ptr];
      return v;
   endfunction

   // Send one request beat; hold valid high on return so back-to-back beats
   // need no second assignment in the same step
   task automatic issue_op(input mode_type op, input logic [DATA_W-1:0] word);
      while (!steady && $urandom_range(99) < 17) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= op;
      req_bus.item_value <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_views.push_back(deque_step(op, word));
   endtask

   // Drop valid and wait until every pending response beat has drained
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write the capacity register only with the engine idle
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      wait_for_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      cap_setting = cap;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Removals on a fresh deque are rejected; one word in and out resets pointers
   task automatic test_empty_removals();
      issue_op(MODE_REM_FRONT, pick_word());
      issue_op(MODE_REM_REAR, pick_word());
      issue_op(MODE_INS_FRONT, 32'h1234_5678);
      issue_op(MODE_REM_REAR, pick_word());
   endtask

   // Capacity 2: fill with both extremes, reject both inserts, wrap the front
   task automatic test_tight_capacity();
      set_capacity(5'd2);
      issue_op(MODE_INS_FRONT, 32'h8000_0000);
      issue_op(MODE_INS_REAR, 32'h7FFF_FFFF);
      issue_op(MODE_INS_FRONT, 32'h0BAD_F00D);
      issue_op(MODE_INS_REAR, 32'h0BAD_F00D);
      issue_op(MODE_REM_FRONT, '0);
      issue_op(MODE_REM_REAR, '0);
      issue_op(MODE_INS_REAR, 32'hFFFF_FFFF);
      issue_op(MODE_INS_FRONT, 32'h0000_0000);
      issue_op(MODE_REM_REAR, '0);
      issue_op(MODE_REM_FRONT, '0);
   endtask

   // Out-of-range capacity: zero behaves as one, 31 behaves as the ring depth
   task automatic test_capacity_clamp();
      set_capacity(5'd0);
      issue_op(MODE_INS_REAR, 32'h5A5A_5A5A);
      issue_op(MODE_INS_FRONT, 32'hA5A5_A5A5);
      issue_op(MODE_REM_FRONT, '0);
      issue_op(MODE_REM_REAR, '0);
      set_capacity(5'd31);
      issue_op(MODE_INS_FRONT, 32'h0000_0001);
      issue_op(MODE_REM_FRONT, '0);
   endtask

   // Fill all sixteen entries from both ends, then hit the full reject
   task automatic test_fill_ring();
      set_capacity(5'd16);
      for (int k = 0; k < RING_DEPTH_DEF; k++)
         issue_op($urandom_range(1) ? MODE_INS_REAR : MODE_INS_FRONT, pick_word());
      issue_op(MODE_INS_REAR, pick_word());
   endtask

   // Shrink the capacity under a full ring: words and pointers stay put
   task automatic test_live_shrink();
      set_capacity(5'd5);
      issue_op(MODE_INS_REAR, pick_word());
      for (int k = 0; k < 12; k++)
         issue_op($urandom_range(1) ? MODE_REM_REAR : MODE_REM_FRONT, pick_word());
      issue_op(MODE_INS_REAR, pick_word());
      issue_op(MODE_INS_FRONT, pick_word());
      issue_op(MODE_INS_REAR, pick_word());
      issue_op(MODE_REM_REAR, pick_word());
      issue_op(MODE_REM_FRONT, pick_word());
   endtask

   // Segments of random traffic, each under its own capacity and insert bias
   task automatic test_random_traffic();
      logic [CAP_W-1:0] cap_list [9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5,
                                        5'd8, 5'd15, 5'd17};
      logic [CAP_W-1:0] cap;
      int unsigned      bias;
      int unsigned      n_ops;
      mode_type         op;
      for (int seg = 0; seg < 20; seg++) begin
         cap = (seg < 9) ? cap_list[seg] : CAP_W'($urandom_range(31));
         // a live capacity change is safe only once every entry holds a word
         if (word_count != 0 && !(&ring_written))
            while (word_count != 0) issue_op(MODE_REM_FRONT, pick_word());
         set_capacity(cap);
         steady = (seg == 6);
         bias   = $urandom_range(20, 80);
         n_ops  = steady ? 80 : 22;
         for (int k = 0; k < n_ops; k++) begin
            if ($urandom_range(99) < 6)
               op = mode_type'($urandom_range(3));
            else if ($urandom_range(99) < bias)
               op = $urandom_range(1) ? MODE_INS_REAR : MODE_INS_FRONT;
            else
               op = $urandom_range(1) ? MODE_REM_REAR : MODE_REM_FRONT;
            issue_op(op, pick_word());
            // now and then hold the sender until the engine is drained
            if ($urandom_range(99) < 2) wait_for_quiet();
         end
         steady = 1'b0;
      end
   endtask

   // Response side: stall ready at random and check every accepted beat
   task automatic check_view();
      deque_view_type e;
      if (expected_views.size() == 0) begin
         $error("response beat with no operation pending");
         mismatches++;
         return;
      end
      e = expected_views.pop_front();
      if (rsp_bus.removed_value !== e.removed_value) begin
         $error("removed_value: expected %0d, got %0d", e.removed_value, rsp_bus.removed_value);
         mismatches++;
      end
      if (rsp_bus.status !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, rsp_bus.status);
         mismatches++;
      end
      if (rsp_bus.occupancy !== e.occupancy) begin
         $error("occupancy: expected %0d, got %0d", e.occupancy, rsp_bus.occupancy);
         mismatches++;
      end
      if (rsp_bus.is_empty !== e.is_empty) begin
         $error("is_empty: expected %0b, got %0b", e.is_empty, rsp_bus.is_empty);
         mismatches++;
      end
      if (rsp_bus.is_full !== e.is_full) begin
         $error("is_full: expected %0b, got %0b", e.is_full, rsp_bus.is_full);
         mismatches++;
      end
      if (rsp_bus.head_value !== e.head_value) begin
         $error("head_value: expected %0d, got %0d", e.head_value, rsp_bus.head_value);
         mismatches++;
      end
      if (rsp_bus.tail_value !== e.tail_value) begin
         $error("tail_value: expected %0d, got %0d", e.tail_value, rsp_bus.tail_value);
         mismatches++;
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_view();
         rsp_bus.ready <= steady || ($urandom_range(99) >= 17);
      end
   end

   // Main sequence: reset, directed cases, random traffic, drain, verdict
   initial begin
      mismatches   = 0;
      steady       = 1'b0;
      head_ptr     = 0;
      tail_ptr     = 0;
      word_count   = 0;
      ring_written = '0;
      cap_setting  = CAP_RESET;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_INS_FRONT;
      req_bus.item_value <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= CAP_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_removals();
      test_tight_capacity();
      test_capacity_clamp();
      test_fill_ring();
      test_live_shrink();
      test_random_traffic();

      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
